>>> sv/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths, reset values and register map for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

    // Fixed width of the base field
    localparam int BASE_WIDTH = 63;

    // Defaults for the top-level parameters
    localparam int MOD_WIDTH_DEF = 31;
    localparam int EXP_WIDTH_DEF = 63;

    // Modulus after reset: 1e9 + 7
    localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

    // APB register map: one 32-bit register, word index in paddr[2]
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MODULUS = 1'b0;

endpackage

`default_nettype wire

>>> sv/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base ** exponent mod modulus with right-to-left
// square-and-multiply on one bit-serial multiply-reduce unit.
// ----------------------------------------------------------------------------
// One item at a time. An item is accepted, its BASE_WIDTH (63) base bits
// are reduced one bit per cycle, every modular product then runs over the
// MOD_WIDTH multiplier bits, and the result is handed to the output
// register. With L the bit length of the exponent and P its number of set
// bits, an item needs P + L - 1 modular products (none when the exponent
// is zero). The shared interleaved multiply-reduce unit retires one
// multiplier bit per cycle. A zero exponent gives 1 for any modulus; a
// modulus written as 0 acts as 1. The modulus register is to be written
// over APB only while the block is idle; the block itself does not
// enforce this. A new item is accepted while the previous result still
// waits on m_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation #(
    parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF,
    parameter int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF,
    localparam int IN_W  = ((modexp_pkg::BASE_WIDTH + EXP_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((MOD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [IN_W-1:0]                   s_tdata,   // base, exponent
    // result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [OUT_W-1:0]                       m_tdata,   // power
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [modexp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [modexp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [modexp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                   pready
);

    localparam int BW    = modexp_pkg::BASE_WIDTH;
    // BASE_WIDTH is always above MOD_WIDTH, so it sizes the bit counter
    localparam int CNT_W = $clog2(BW);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;  // base mod m, one bit per cycle
    localparam logic [2:0] ST_MUL    = 3'd2;  // acc = acc * b mod m
    localparam logic [2:0] ST_SQR    = 3'd3;  // b = b * b mod m
    localparam logic [2:0] ST_DONE   = 3'd4;  // wait for output register

    // control
    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MOD_WIDTH-1:0] modulus_reg, modulus_next;

    // datapath
    logic [BW-1:0]        base_sr_reg, base_sr_next;   // base, MSB first
    logic [EXP_WIDTH-1:0] exp_reg, exp_next;           // exponent, LSB first
    logic [MOD_WIDTH-1:0] acc_reg, acc_next;
    logic [MOD_WIDTH-1:0] b_reg, b_next;
    logic [MOD_WIDTH-1:0] r_reg, r_next;               // partial remainder
    logic [MOD_WIDTH-1:0] y_reg, y_next;               // multiplier, MSB first
    logic [MOD_WIDTH-1:0] m_reg, m_next;               // modulus in use
    logic [MOD_WIDTH-1:0] power_reg, power_next;

    // step unit: r' = (2r + addend) mod m, addend < m or a single bit
    logic [MOD_WIDTH-1:0] addend;
    logic [MOD_WIDTH+1:0] sum;
    logic [MOD_WIDTH+1:0] m1;
    logic [MOD_WIDTH+1:0] m2;
    logic [MOD_WIDTH+1:0] r_step;
    logic [MOD_WIDTH-1:0] r_new;
    logic [EXP_WIDTH-1:0] exp_shr;
    logic                 cfg_wr;

    assign addend = (state_reg == ST_REDUCE) ? MOD_WIDTH'(base_sr_reg[BW-1])
                  : (y_reg[MOD_WIDTH-1] ? b_reg : '0);
    assign sum    = {1'b0, r_reg, 1'b0} + {2'b00, addend};
    assign m1     = {2'b00, m_reg};
    assign m2     = {1'b0, m_reg, 1'b0};

    always_comb
    begin
        if (sum >= m2)
        begin
            r_step = sum - m2;
        end
        else if (sum >= m1)
        begin
            r_step = sum - m1;
        end
        else
        begin
            r_step = sum;
        end
    end

    assign r_new   = r_step[MOD_WIDTH-1:0];
    assign exp_shr = exp_reg >> 1;
    assign cfg_wr  = psel && penable && pwrite
                  && (paddr[modexp_pkg::APB_ADDR_W-1] == modexp_pkg::REG_MODULUS);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        modulus_next   = modulus_reg;
        base_sr_next   = base_sr_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        y_next         = y_reg;
        m_next         = m_reg;
        power_next     = power_reg;

        if (cfg_wr)
        begin
            modulus_next = pwdata[MOD_WIDTH-1:0];
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    base_sr_next = s_tdata[BW-1:0];
                    exp_next     = s_tdata[BW+EXP_WIDTH-1:BW];
                    acc_next     = MOD_WIDTH'(1);
                    r_next       = '0;
                    cnt_next     = CNT_W'(BW - 1);
                    // a zero modulus behaves as one
                    m_next       = (modulus_reg == '0) ? MOD_WIDTH'(1) : modulus_reg;
                    state_next   = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                base_sr_next = {base_sr_reg[BW-2:0], 1'b0};
                r_next       = r_new;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    b_next   = r_new;
                    r_next   = '0;
                    cnt_next = CNT_W'(MOD_WIDTH - 1);
                    if (exp_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (exp_reg[0])
                    begin
                        y_next     = acc_reg;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        y_next     = r_new;
                        state_next = ST_SQR;
                    end
                end
            end
            ST_MUL:
            begin
                y_next   = {y_reg[MOD_WIDTH-2:0], 1'b0};
                r_next   = r_new;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    acc_next = r_new;
                    r_next   = '0;
                    cnt_next = CNT_W'(MOD_WIDTH - 1);
                    // last set bit: the final squaring is not needed
                    if (exp_shr == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        y_next     = b_reg;
                        state_next = ST_SQR;
                    end
                end
            end
            ST_SQR:
            begin
                y_next   = {y_reg[MOD_WIDTH-2:0], 1'b0};
                r_next   = r_new;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    b_next   = r_new;
                    exp_next = exp_shr;
                    r_next   = '0;
                    cnt_next = CNT_W'(MOD_WIDTH - 1);
                    if (exp_shr == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (exp_shr[0])
                    begin
                        y_next     = acc_reg;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        y_next     = r_new;
                        state_next = ST_SQR;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    power_next     = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            modulus_reg   <= modexp_pkg::MODULUS_RESET[MOD_WIDTH-1:0];
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            modulus_reg   <= modulus_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_sr_reg <= base_sr_next;
        exp_reg     <= exp_next;
        acc_reg     <= acc_next;
        b_reg       <= b_next;
        r_reg       <= r_next;
        y_reg       <= y_next;
        m_reg       <= m_next;
        power_reg   <= power_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(power_reg);
    assign pready   = 1'b1;
    assign prdata   = (paddr[modexp_pkg::APB_ADDR_W-1] == modexp_pkg::REG_MODULUS)
                    ? modexp_pkg::APB_DATA_W'(modulus_reg) : '0;

    // remainder stays reduced during the base reduction
    a_reduce_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REDUCE) |-> (m_reg != '0 && r_reg < m_reg))
        else $error("partial remainder out of range in base reduction");

    // both remainder and the running square stay below the modulus
    a_mul_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_SQR)
        |-> (r_reg < m_reg && b_reg < m_reg))
        else $error("operand out of range in multiply-reduce");

    // an accepted item always starts with the base reduction
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_REDUCE))
        else $error("accepted item did not start base reduction");

    // a new result only comes from the hand-off state
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result register loaded outside hand-off");

endmodule

`default_nettype wire

>>> verif/modexp_checker.sv
// ----------------------------------------------------------------------------
// modexp_checker
// Watches the item, result and APB channels of the modular exponentiation
// block, predicts each power from its own copy of the modulus and compares
// results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modexp_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [127:0]                      s_tdata,   // base, exponent
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [31:0]                       m_tdata,   // power
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [modexp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [modexp_pkg::APB_DATA_W-1:0] pwdata,
    input  wire logic                              pready,
    output int                                     mismatches,
    output int                                     pending
);

    localparam int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF;
    localparam int EXP_WIDTH = modexp_pkg::EXP_WIDTH_DEF;
    localparam int BASE_W    = modexp_pkg::BASE_WIDTH;

    logic [MOD_WIDTH-1:0] modulus;
    logic [MOD_WIDTH-1:0] power_q[$];
    logic [MOD_WIDTH-1:0] got_power;
    logic [MOD_WIDTH-1:0] want_power;
    int                   mismatch_count = 0;
    int                   result_index   = 0;

    assign mismatches = mismatch_count;

    // Right-to-left square-and-multiply; products stay below 2^62.
    function automatic logic [MOD_WIDTH-1:0] power_mod(
        input logic [BASE_W-1:0]    base,
        input logic [EXP_WIDTH-1:0] expo,
        input logic [MOD_WIDTH-1:0] m
    );
        logic [63:0]          mm;
        logic [63:0]          sq;
        logic [63:0]          acc;
        logic [EXP_WIDTH-1:0] e;
        mm  = (m == '0) ? 64'd1 : 64'(m);   // zero acts as one
        sq  = 64'(base) % mm;
        acc = 64'd1;
        e   = expo;
        while (e != '0)
        begin
            if (e[0])
                acc = (acc * sq) % mm;
            sq = (sq * sq) % mm;
            e  = e >> 1;
        end
        return acc[MOD_WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus <= modexp_pkg::MODULUS_RESET;
            power_q.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == modexp_pkg::REG_MODULUS)
                modulus <= pwdata[MOD_WIDTH-1:0];
            if (s_tvalid && s_tready)
                power_q.insert(power_q.size(),
                               power_mod(s_tdata[BASE_W-1:0],
                                         s_tdata[BASE_W +: EXP_WIDTH], modulus));
            if (m_tvalid && m_tready)
            begin
                got_power = m_tdata[MOD_WIDTH-1:0];
                if (power_q.size() == 0)
                    report_mismatch($sformatf("result %0d power %0d with no item waiting",
                                              result_index, got_power));
                else
                begin
                    want_power = power_q.pop_front();
                    if (got_power != want_power)
                        report_mismatch($sformatf("result %0d power %0d, wanted %0d",
                                                  result_index, got_power, want_power));
                end
                result_index++;
            end
            pending <= power_q.size();
        end
    end

endmodule

>>> verif/tb_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// tb_modular_exponentiation
// Regression for the modular exponentiation block: directed corner items,
// then random items under several moduli, with random gaps on the input
// side and random stalls on the result side; modexp_checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_modular_exponentiation;

    localparam int  IN_W         = 128;
    localparam int  OUT_W        = 32;
    // Watchdog limit, above the whole run with gaps and stalls at their longest.
    localparam int  CYCLE_LIMIT  = 3_000_000;
    // Quiet time after the last result.
    localparam int  DRAIN_CYCLES = 4096;
    localparam int  RANDOM_PHASES = 6;
    localparam int  PHASE_ITEMS   = 20;

    localparam logic [62:0] ALL_ONES = {63{1'b1}};
    localparam logic [62:0] ALT_LO   = {1'b1, {31{2'b01}}};   // 0x5555...
    localparam logic [62:0] ALT_HI   = ~ALT_LO;               // 0x2AAA...
    localparam logic [modexp_pkg::APB_ADDR_W-1:0] MODULUS_ADDR =
        {modexp_pkg::REG_MODULUS, 2'b00};

    logic                                  clk      = 1'b0;
    logic                                  rst_n    = 1'b0;
    logic                                  s_tvalid = 1'b0;
    logic                                  s_tready;
    logic [IN_W-1:0]                       s_tdata  = '0;  // [62:0] base, [125:63] exponent
    logic                                  m_tvalid;
    logic                                  m_tready = 1'b0;
    logic [OUT_W-1:0]                      m_tdata;        // [30:0] power, pad
    logic                                  psel     = 1'b0;
    logic                                  penable  = 1'b0;
    logic                                  pwrite   = 1'b0;
    logic [modexp_pkg::APB_ADDR_W-1:0]     paddr    = '0;
    logic [modexp_pkg::APB_DATA_W-1:0]     pwdata   = '0;
    logic [modexp_pkg::APB_DATA_W-1:0]     prdata;
    logic                                  pready;

    int                    mismatches;
    int                    pending;
    int                    cycle_count = 0;
    bit                    no_gaps     = 1'b0;
    logic [30:0]           cur_modulus = modexp_pkg::MODULUS_RESET;

    always #5 clk = ~clk;

    modular_exponentiation dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    modexp_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("modular_exponentiation regression: fail");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 20);
        else
            return $urandom_range(50, 300);
    endfunction

    function automatic logic [62:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    // Result side: ready runs of random length broken by stalls.
    initial
    begin
        @(posedge clk iff rst_n);
        forever
        begin
            m_tready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? 3000 : $urandom_range(1, 40))
                @(posedge clk);
            if ($urandom_range(0, 9) < 7)
            begin
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_modulus(input logic [modexp_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODULUS_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk iff pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_modulus = value[30:0];
        @(posedge clk);
    endtask

    // Offer one item and hold it until taken. tvalid stays high when the
    // next item follows at once, so it is never lowered and raised in one step.
    task automatic send_item(input logic [62:0] base, input logic [62:0] expo);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, expo, base};
        @(posedge clk iff s_tready);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Close a phase: stop offering, then wait until every result is out.
    // Every item yields a result, so the block is idle once pending is 0.
    task automatic drain_phase();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random modulus: small, anywhere, near the top, or a familiar prime.
    // Bit 31 of the write is random and must be ignored.
    function automatic logic [modexp_pkg::APB_DATA_W-1:0] pick_modulus();
        logic [30:0] m;
        case ($urandom_range(0, 5))
            0:       m = 31'($urandom_range(1, 64));
            1:       m = 31'($urandom_range(2147483647 - 64, 2147483647));
            2:       m = 31'd998244353;
            3:       m = 31'd1000000007;
            default: m = 31'($urandom_range(1, 2147483647));
        endcase
        return {1'($urandom_range(0, 1)), m};
    endfunction

    function automatic logic [62:0] pick_base();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return rand63();
        else if (roll < 8)
            return 63'($urandom_range(0, 10));
        else
            // a multiple of the modulus plus a little
            return 63'($urandom_range(0, 1000)) * 63'(cur_modulus) +
                   63'($urandom_range(0, 2));
    endfunction

    // Full-width exponents are slow; most are shorter random lengths.
    function automatic logic [62:0] pick_exponent();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 6)
            return rand63();
        else if (roll < 14)
            return rand63() >> $urandom_range(1, 62);
        else if (roll < 17)
            return 63'($urandom_range(0, 16));
        else if (roll < 19)
            return ALL_ONES >> $urandom_range(0, 62);
        else
            return '0;
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset modulus (1e9 + 7): zero cases, extremes, base at the modulus.
        send_item('0, '0);
        send_item('0, 63'd1);
        send_item('0, ALL_ONES);
        send_item(ALL_ONES, '0);
        send_item(ALL_ONES, ALL_ONES);
        send_item(63'd1, ALL_ONES);
        send_item(63'd2, 63'd10);
        send_item(63'd2, 63'd30);
        send_item(63'(modexp_pkg::MODULUS_RESET), 63'd5);
        send_item(63'(modexp_pkg::MODULUS_RESET) - 63'd1, 63'd2);
        send_item(63'(modexp_pkg::MODULUS_RESET) + 63'd1, ALL_ONES);
        send_item(63'd3, 63'd1);
        send_item(ALT_LO, ALT_HI);
        send_item(ALT_HI, ALT_LO);
        drain_phase();

        // Modulus one: zero exponent still gives 1, anything else 0.
        write_modulus(32'd1);
        send_item(63'd5, '0);
        send_item(63'd5, 63'd7);
        send_item(ALL_ONES, ALL_ONES);
        drain_phase();

        // Modulus written as zero acts as one.
        write_modulus(32'd0);
        send_item('0, '0);
        send_item(63'd9, 63'd3);
        drain_phase();

        // Largest modulus.
        write_modulus(32'h7FFF_FFFF);
        send_item(ALL_ONES, ALL_ONES);
        send_item(63'h7FFF_FFFE, 63'd2);
        send_item(63'h8000_0000, 63'd1);
        drain_phase();

        // Bit 31 of the write is dropped: modulus 2.
        write_modulus(32'h8000_0002);
        send_item(63'd3, ALL_ONES);
        send_item(63'd4, 63'd1);
        drain_phase();

        // Random phases, one without any input gaps.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_modulus(pick_modulus());
            no_gaps = (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(pick_base(), pick_exponent());
            drain_phase();
        end
        no_gaps = 1'b0;

        // Nothing may trickle out after the last result.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("modular_exponentiation regression: pass");
        else
            $display("modular_exponentiation regression: fail");
        $finish;
    end

endmodule
